// ===== design/stp_pkg.sv =====
// Shared types and codes for the software timer pool.
package stp_pkg;

    typedef enum logic [2:0] {
        CMD_CREATE     = 3'd0,
        CMD_DESTROY    = 3'd1,
        CMD_SET        = 3'd2,
        CMD_RESET      = 3'd3,
        CMD_FIN_RESET  = 3'd4,
        CMD_QUERY      = 3'd5,
        CMD_TICK       = 3'd6,
        CMD_COUNT      = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_TIMER = 2'd1,
        STAT_FULL     = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd               cmd;
        logic [8:0]         timer_id;
        logic signed [31:0] duration;
        logic [15:0]        elapsed;
    } t_req;

    typedef struct packed {
        logic signed [31:0] value;
        logic               finished;
        t_status            status;
    } t_rsp;

endpackage

// ===== design/stp_if.sv =====
// Valid/ready channel interfaces for command and response transactions.
interface stp_req_if import stp_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface stp_rsp_if import stp_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/software_timer_pool_unit.sv =====
// Software timer pool: countdown timers with reload held in block memories.
//
// Channels: i_req carries one command transaction (cmd, timer_id, duration,
// elapsed); o_rsp returns exactly one response transaction (value, finished,
// status) per command, in order. Both are valid/ready.
// Flow: destroy, set, reset, finished_reset and query read their slot, act on it in
// the access state, and the done state then hands the response over; count goes
// straight to the done state. Create and tick stream over the slot memory one entry
// a cycle (read one slot, write back the previous); tick visits every slot, while
// create stops at the lowest free slot (or after the last slot when the pool is full).
// Throughput: one command at a time; the next is accepted once the current
// one has handed its response to the output register.
// Reset: a clearing pass writes every slot free, one slot a cycle; no command is
// accepted during it.
// Stall: the output register holds a response until o_rsp.ready; a new command
// may be accepted meanwhile, and its own response waits in a holding state.
module software_timer_pool_unit import stp_pkg::*; #(
    parameter int TIMER_COUNT = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stp_req_if.sink   i_req,
    stp_rsp_if.source o_rsp
);

    localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int CW = $clog2(TIMER_COUNT + 1);
    localparam logic [IW-1:0] LAST = IW'(TIMER_COUNT - 1);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_ACCESS = 5'b00100,
        ST_SWEEP  = 5'b01000,
        ST_DONE   = 5'b10000
    } t_state;

    // Slot memory: {in-use, remaining}; reload kept alongside.
    logic [32:0] mem_rem [TIMER_COUNT];
    logic [31:0] mem_rld [TIMER_COUNT];

    t_state       r_state, n_state;
    t_req         r_req, n_req;
    logic         r_id_ok, n_id_ok;
    logic [IW-1:0] r_addr, n_addr;
    logic         r_more, n_more;
    logic [IW-1:0] r_paddr, n_paddr;
    logic [CW-1:0] r_used_cnt, n_used_cnt;
    t_rsp         r_pend, n_pend;
    logic         r_out_valid, n_out_valid;
    t_rsp         r_out, n_out;
    logic [32:0]  r_rd_rem;
    logic [31:0]  r_rd_rld;

    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          wr_en_rem, wr_en_rld;
    logic [32:0]   wr_rem;
    logic [31:0]   wr_rld;

    logic [IW-1:0] id_idx;
    logic          id_ok;
    logic          accept;
    logic          cur_used;
    logic [31:0]   cur_rem;
    logic          cur_np;
    logic          present;
    logic          create_hit;

    assign id_idx   = IW'(i_req.data.timer_id);
    assign id_ok    = (32'(i_req.data.timer_id) < 32'(TIMER_COUNT));
    assign accept   = i_req.valid && i_req.ready;
    assign cur_used = r_rd_rem[32];
    assign cur_rem  = r_rd_rem[31:0];
    // Not positive: zero or negative.
    assign cur_np   = (cur_rem == 32'd0) || cur_rem[31];
    assign present  = r_id_ok && cur_used;
    assign create_hit = (r_state == ST_SWEEP) && (r_req.cmd == CMD_CREATE) && !cur_used;

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_id_ok     = r_id_ok;
        n_addr      = r_addr;
        n_more      = r_more;
        n_paddr     = r_paddr;
        n_used_cnt  = r_used_cnt;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        rd_addr     = r_addr;
        wr_addr     = r_paddr;
        wr_en_rem   = 1'b0;
        wr_en_rld   = 1'b0;
        wr_rem      = r_rd_rem;
        wr_rld      = r_rd_rld;

        unique case (r_state)
            ST_CLEAR: begin
                // Mark one slot free per cycle.
                wr_en_rem = 1'b1;
                wr_addr   = r_addr;
                wr_rem    = '0;
                n_addr    = r_addr + IW'(1);
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_req   = i_req.data;
                    n_id_ok = id_ok;
                    case (i_req.data.cmd) inside
                        CMD_CREATE, CMD_TICK: begin
                            rd_addr = '0;
                            n_paddr = '0;
                            n_addr  = IW'(1);
                            n_more  = (LAST != '0);
                            n_state = ST_SWEEP;
                        end
                        CMD_COUNT: begin
                            n_pend  = '{value: 32'(r_used_cnt), finished: 1'b0,
                                        status: STAT_OK};
                            n_state = ST_DONE;
                        end
                        default: begin
                            rd_addr = id_idx;
                            n_state = ST_ACCESS;
                        end
                    endcase
                end
            end
            ST_ACCESS: begin
                wr_addr = IW'(r_req.timer_id);
                n_pend  = '{value: '0, finished: 1'b0, status: STAT_OK};
                n_state = ST_DONE;
                if (!present) begin
                    n_pend.status   = STAT_NO_TIMER;
                    n_pend.finished = (r_req.cmd == CMD_FIN_RESET) ||
                                      (r_req.cmd == CMD_QUERY);
                end else begin
                    unique case (r_req.cmd)
                        CMD_DESTROY: begin
                            wr_en_rem  = 1'b1;
                            wr_rem     = {1'b0, cur_rem};
                            n_used_cnt = r_used_cnt - CW'(1);
                        end
                        CMD_SET: begin
                            n_pend.value = cur_rem;
                            wr_en_rem    = 1'b1;
                            wr_en_rld    = 1'b1;
                            wr_rem       = {1'b1, r_req.duration};
                            wr_rld       = r_req.duration;
                        end
                        CMD_RESET: begin
                            n_pend.value = cur_rem;
                            wr_en_rem    = 1'b1;
                            wr_rem       = {1'b1, r_rd_rld};
                        end
                        CMD_FIN_RESET: begin
                            n_pend.value    = cur_rem;
                            n_pend.finished = cur_np;
                            wr_en_rem       = cur_np;
                            wr_rem          = {1'b1, r_rd_rld};
                        end
                        CMD_QUERY: begin
                            n_pend.value    = cur_rem;
                            n_pend.finished = cur_np;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                // Read the next slot while writing back the one just read.
                if (r_more) begin
                    rd_addr = r_addr;
                    n_paddr = r_addr;
                    n_addr  = r_addr + IW'(1);
                    n_more  = (r_addr != LAST);
                end
                if (r_req.cmd == CMD_TICK) begin
                    wr_en_rem = cur_used && !cur_np;
                    wr_rem    = {1'b1, cur_rem - 32'(r_req.elapsed)};
                    if (!r_more) begin
                        n_pend  = '{value: '0, finished: 1'b0, status: STAT_OK};
                        n_state = ST_DONE;
                    end
                end else if (create_hit) begin
                    wr_en_rem  = 1'b1;
                    wr_en_rld  = 1'b1;
                    wr_rem     = {1'b1, r_req.duration};
                    wr_rld     = r_req.duration;
                    n_used_cnt = r_used_cnt + CW'(1);
                    n_pend     = '{value: 32'(r_paddr), finished: 1'b0, status: STAT_OK};
                    n_state    = ST_DONE;
                end else if (!r_more) begin
                    n_pend  = '{value: '1, finished: 1'b0, status: STAT_FULL};
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hand the response over once the output register is free.
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_more      <= 1'b0;
            r_used_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_more      <= n_more;
            r_used_cnt  <= n_used_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_id_ok <= n_id_ok;
        r_paddr <= n_paddr;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

    // Slot memories: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en_rem) begin
            mem_rem[wr_addr] <= wr_rem;
        end
        r_rd_rem <= mem_rem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en_rld) begin
            mem_rld[wr_addr] <= wr_rld;
        end
        r_rd_rld <= mem_rld[rd_addr];
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used_cnt) <= 32'(TIMER_COUNT))
        else $error("used slot count beyond pool size");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_DONE) |-> (!wr_en_rem && !wr_en_rld))
        else $error("slot memory written while no command is at work");

    a_create_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        create_hit |=> (r_used_cnt == $past(r_used_cnt) + CW'(1)))
        else $error("create did not advance the used count");

    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_valid && !r_out_valid) |-> (r_state == ST_DONE))
        else $error("response raised outside the hand-over state");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (!accept && !r_out_valid))
        else $error("traffic during the clearing pass");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the software timer pool: directed and random command streams.
module testbench;
    import stp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIMERS       = 512;
    localparam int ITEM_BUDGET  = 1170;
    localparam int FILL_AFTER   = 400;
    localparam int REPORT_LINES = 40;

    // Timer pool predictor and store of responses not yet seen.
    class timer_pool_scoreboard;
        logic signed [31:0] remaining [TIMERS];
        logic signed [31:0] reload [TIMERS];
        bit                 used [TIMERS];
        int unsigned        in_use;
        t_rsp               awaited [$];
        int unsigned        rsp_seen;
        int unsigned        errors;

        function new();
            for (int k = 0; k < TIMERS; k++) begin
                used[k] = 1'b0;
            end
            in_use   = 0;
            rsp_seen = 0;
            errors   = 0;
        endfunction

        // Apply one accepted command to the pool and queue its response.
        function void note_command(t_req req);
            t_rsp resp;
            bit   live;
            bit   placed;
            resp.value    = 32'sd0;
            resp.finished = 1'b0;
            resp.status   = STAT_OK;
            live   = used[req.timer_id];
            placed = 1'b0;
            case (req.cmd)
                CMD_CREATE: begin
                    resp.value  = -32'sd1;
                    resp.status = STAT_FULL;
                    for (int k = 0; k < TIMERS; k++) begin
                        if (!placed && !used[k]) begin
                            remaining[k] = req.duration;
                            reload[k]    = req.duration;
                            used[k]      = 1'b1;
                            in_use++;
                            resp.value  = k;
                            resp.status = STAT_OK;
                            placed      = 1'b1;
                        end
                    end
                end
                CMD_DESTROY: begin
                    if (live) begin
                        used[req.timer_id] = 1'b0;
                        in_use--;
                    end else begin
                        resp.status = STAT_NO_TIMER;
                    end
                end
                CMD_SET: begin
                    if (live) begin
                        resp.value = remaining[req.timer_id];
                        remaining[req.timer_id] = req.duration;
                        reload[req.timer_id]    = req.duration;
                    end else begin
                        resp.status = STAT_NO_TIMER;
                    end
                end
                CMD_RESET: begin
                    if (live) begin
                        resp.value = remaining[req.timer_id];
                        remaining[req.timer_id] = reload[req.timer_id];
                    end else begin
                        resp.status = STAT_NO_TIMER;
                    end
                end
                CMD_FIN_RESET: begin
                    if (live) begin
                        resp.value = remaining[req.timer_id];
                        if (resp.value <= 0) begin
                            resp.finished = 1'b1;
                            remaining[req.timer_id] = reload[req.timer_id];
                        end
                    end else begin
                        resp.finished = 1'b1;
                        resp.status   = STAT_NO_TIMER;
                    end
                end
                CMD_QUERY: begin
                    if (live) begin
                        resp.value    = remaining[req.timer_id];
                        resp.finished = (resp.value <= 0);
                    end else begin
                        resp.finished = 1'b1;
                        resp.status   = STAT_NO_TIMER;
                    end
                end
                CMD_TICK: begin
                    for (int k = 0; k < TIMERS; k++) begin
                        if (used[k] && remaining[k] > 0) begin
                            remaining[k] = remaining[k] - $signed({16'd0, req.elapsed});
                        end
                    end
                end
                default: begin
                    resp.value = in_use;
                end
            endcase
            awaited.push_back(resp);
        endfunction

        task report(string what);
            errors++;
            if (errors <= REPORT_LINES) begin
                $display("tb: mismatch at response %0d: %s", rsp_seen, what);
            end
        endtask

        task check_response(t_rsp got);
            t_rsp want;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected response, value %0d status %0d",
                                 got.value, got.status));
            end else begin
                want = awaited.pop_front();
                if (got.value !== want.value) begin
                    report($sformatf("value %0d, predicted %0d", got.value, want.value));
                end
                if (got.finished !== want.finished) begin
                    report($sformatf("finished %b, predicted %b",
                                     got.finished, want.finished));
                end
                if (got.status !== want.status) begin
                    report($sformatf("status %0d, predicted %0d", got.status, want.status));
                end
            end
            rsp_seen++;
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    stp_req_if req_ch ();
    stp_rsp_if rsp_ch ();

    timer_pool_scoreboard sb = new();

    // Quiet stretches: no sender gaps and the sink always ready.
    bit quiet = 1'b0;
    int unsigned n_sent = 0;
    int pool_target = 30;

    software_timer_pool_unit #(
        .TIMER_COUNT (TIMERS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    // Mostly short idles, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Small values dominate so that ticks drive timers through zero.
    function automatic int pick_duration();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return $urandom_range(0, 3000);
        end else if (roll < 65) begin
            return -int'($urandom_range(0, 100));
        end else if (roll < 82) begin
            return $urandom;
        end
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 1;
            2:       return -1;
            3:       return 32'h7FFF_FFFF;
            default: return 32'h8000_0000;
        endcase
    endfunction

    function automatic int pick_elapsed();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return $urandom_range(0, 800);
        end else if (roll < 92) begin
            return $urandom_range(0, 65535);
        end
        return ($urandom_range(0, 1) == 1) ? 65535 : 0;
    endfunction

    // Address a live timer most of the time, otherwise any slot or a free one.
    function automatic int pick_timer_id();
        int roll;
        int start;
        roll  = $urandom_range(0, 99);
        start = $urandom_range(0, TIMERS - 1);
        if (roll < 75 && sb.in_use > 0) begin
            for (int k = 0; k < TIMERS; k++) begin
                if (sb.used[(start + k) % TIMERS]) begin
                    return (start + k) % TIMERS;
                end
            end
        end else if (roll >= 90 && sb.in_use < TIMERS) begin
            for (int k = 0; k < TIMERS; k++) begin
                if (!sb.used[(start + k) % TIMERS]) begin
                    return (start + k) % TIMERS;
                end
            end
        end
        return start;
    endfunction

    // Drive one command transaction from a falling edge and hold it until accepted.
    task automatic issue(t_cmd cmd, int timer_id, int duration, int elapsed);
        t_req req;
        int   gap;
        req.cmd      = cmd;
        req.timer_id = 9'(timer_id);
        req.duration = duration;
        req.elapsed  = 16'(elapsed);
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= req;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        sb.note_command(req);
        n_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every response has been returned.
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (sb.awaited.size() != 0);
    endtask

    task automatic issue_random_command();
        t_cmd cmd;
        int   roll;
        roll = $urandom_range(0, 99);
        if (roll < 14)      cmd = CMD_CREATE;
        else if (roll < 24) cmd = CMD_DESTROY;
        else if (roll < 34) cmd = CMD_SET;
        else if (roll < 44) cmd = CMD_RESET;
        else if (roll < 58) cmd = CMD_FIN_RESET;
        else if (roll < 72) cmd = CMD_QUERY;
        else if (roll < 86) cmd = CMD_TICK;
        else                cmd = CMD_COUNT;
        // Steer the pool occupancy towards the current target.
        if (cmd == CMD_CREATE && sb.in_use > pool_target) begin
            cmd = CMD_DESTROY;
        end else if (cmd == CMD_DESTROY && sb.in_use < pool_target / 4) begin
            cmd = CMD_CREATE;
        end
        issue(cmd, pick_timer_id(), pick_duration(), pick_elapsed());
    endtask

    // Response sink: alternate runs of ready and stall, with the odd long stall.
    initial begin : rsp_sink
        int  run;
        bit  level;
        run = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (quiet) begin
                rsp_ch.ready <= 1'b1;
                run = 0;
            end else if (run > 0) begin
                run--;
            end else begin
                level = ($urandom_range(0, 2) != 0);
                if (level) begin
                    run = $urandom_range(0, 8);
                end else if ($urandom_range(0, 9) == 0) begin
                    run = $urandom_range(15, 50);
                end else begin
                    run = $urandom_range(0, 3);
                end
                rsp_ch.ready <= level;
            end
        end
    end

    // Check every response transaction at the rising edge it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            sb.check_response(rsp_ch.data);
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #(64'd40_000_000);
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        bit filled;
        int len;
        filled       = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        i_rst_n      = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty pool, missing timers, extreme durations, expiry and reload.
        quiet = 1'b1;
        issue(CMD_COUNT, 0, 0, 0);
        issue(CMD_QUERY, 0, 0, 0);
        issue(CMD_DESTROY, 5, 0, 0);
        issue(CMD_SET, 7, 55, 0);
        issue(CMD_RESET, 511, 0, 0);
        issue(CMD_FIN_RESET, 511, 0, 0);
        issue(CMD_CREATE, 0, 32'h7FFF_FFFF, 0);
        issue(CMD_CREATE, 0, 32'h8000_0000, 0);
        issue(CMD_CREATE, 0, 0, 0);
        issue(CMD_CREATE, 0, 1, 0);
        issue(CMD_CREATE, 0, 100, 0);
        issue(CMD_QUERY, 1, 0, 0);
        issue(CMD_QUERY, 2, 0, 0);
        issue(CMD_TICK, 0, 0, 65535);
        issue(CMD_TICK, 0, 0, 0);
        issue(CMD_FIN_RESET, 1, 0, 0);
        issue(CMD_FIN_RESET, 3, 0, 0);
        issue(CMD_FIN_RESET, 0, 0, 0);
        issue(CMD_SET, 4, -1, 0);
        issue(CMD_RESET, 0, 0, 0);
        // Freeing a middle slot makes it the lowest free one again.
        issue(CMD_DESTROY, 2, 0, 0);
        issue(CMD_CREATE, 0, 7, 0);
        issue(CMD_COUNT, 0, 0, 0);
        issue(CMD_QUERY, 3, 0, 0);
        hold_until_drained();

        while (n_sent < ITEM_BUDGET) begin
            quiet = ($urandom_range(0, 3) == 0);
            if (!filled && n_sent >= FILL_AFTER) begin
                // Fill the pool, then push creates against a full pool.
                while (sb.in_use < TIMERS) begin
                    issue(CMD_CREATE, pick_timer_id(), pick_duration(), pick_elapsed());
                end
                repeat (4) issue(CMD_CREATE, pick_timer_id(), pick_duration(), 0);
                issue(CMD_COUNT, pick_timer_id(), pick_duration(), pick_elapsed());
                issue(CMD_QUERY, TIMERS - 1, 0, 0);
                issue(CMD_TICK, 0, 0, pick_elapsed());
                hold_until_drained();
                filled      = 1'b1;
                pool_target = TIMERS - 8;
            end else begin
                len = $urandom_range(30, 80);
                repeat (len) issue_random_command();
            end
        end

        quiet = 1'b1;
        hold_until_drained();
        repeat (TIMERS + 16) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/stp_pkg.sv
design/stp_if.sv
design/software_timer_pool_unit.sv
sim/testbench.sv
